/* rtl/core/ile_pkg.sv */
// Shared types and constants of the indexed list engine.
// Holds the request/result structs, command and status codes, and the RAM port bundle.
// No dependencies.
package ile_pkg;

	localparam int CAPACITY  = 64;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 7;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CMP_W-1:0]     cmp_t;
	typedef logic [CNT_OUT_W-1:0] cnt_out_t;

	localparam logic [2:0] CMD_READ     = 3'd0;
	localparam logic [2:0] CMD_INS_HEAD = 3'd1;
	localparam logic [2:0] CMD_INS_TAIL = 3'd2;
	localparam logic [2:0] CMD_INS_AT   = 3'd3;
	localparam logic [2:0] CMD_DELETE   = 3'd4;
	localparam logic [2:0] CMD_CLEAR    = 3'd5;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]              cmd;
		logic signed [7:0]       position;
		logic signed [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [1:0]              status;
		cnt_out_t                count_now;
	} rsp_t;

	typedef struct packed {
		logic             we;
		addr_t            waddr;
		logic [VAL_W-1:0] wdata;
		logic             re;
		addr_t            raddr;
	} ram_req_t;

endpackage

/* rtl/core/ile_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/ile_ctrl.sv */
// Command sequencer of the indexed list engine: decode, element count, shift loop.
// Depends on ile_pkg; drives one ile_ram instance through a ram_req_t bundle.
module ile_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ile_pkg::req_t     req,
	output logic              busy,
	output ile_pkg::ram_req_t ram,
	input  logic [31:0]       rdata,
	output logic              rsp_vld,
	output ile_pkg::rsp_t     rsp
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_RDWAIT = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;

	logic [1:0]        state_q;
	ile_pkg::cnt_t     count_q;
	ile_pkg::addr_t    ptr_q;
	ile_pkg::cnt_t     left_q;
	ile_pkg::addr_t    at_q;
	logic [31:0]       val_q;
	logic              del_q;
	logic              pend_s1;
	ile_pkg::addr_t    waddr_s1;

	logic              accept;
	logic              neg;
	ile_pkg::cmp_t     pos_ext;
	ile_pkg::cmp_t     cnt_ext;
	ile_pkg::cmp_t     ins_at;
	ile_pkg::cmp_t     ins_left;
	ile_pkg::cmp_t     del_left;
	ile_pkg::cmp_t     pos_p1;
	ile_pkg::cnt_t     cnt_m1;
	ile_pkg::cnt_t     cnt_p1;
	logic              in_range;
	logic              full;
	logic              go_rd;
	logic              go_ins;
	logic              go_del;
	logic              clr;
	logic              shift_done;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign neg      = req.position[7];
	assign pos_ext  = neg ? '0 : ile_pkg::cmp_t'(req.position[6:0]);
	assign cnt_ext  = ile_pkg::cmp_t'(count_q);
	assign in_range = !neg && (pos_ext < cnt_ext);
	assign full     = (count_q == ile_pkg::cnt_t'(ile_pkg::CAPACITY));
	assign cnt_m1   = count_q - ile_pkg::cnt_t'(1);
	assign cnt_p1   = count_q + ile_pkg::cnt_t'(1);
	assign ins_left = cnt_ext - ins_at;
	assign del_left = cnt_ext - pos_ext - ile_pkg::cmp_t'(1);
	assign pos_p1   = pos_ext + ile_pkg::cmp_t'(1);

	always_comb begin
		unique case (req.cmd) inside
			ile_pkg::CMD_INS_HEAD: ins_at = '0;
			ile_pkg::CMD_INS_TAIL: ins_at = cnt_ext;
			default:               ins_at = pos_ext;
		endcase
	end

	always_comb begin
		ram            = '0;
		rsp_vld        = 1'b0;
		rsp.read_value = '0;
		rsp.status     = ile_pkg::ST_DONE;
		rsp.count_now  = ile_pkg::cnt_out_t'(count_q);
		go_rd          = 1'b0;
		go_ins         = 1'b0;
		go_del         = 1'b0;
		clr            = 1'b0;
		shift_done     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.cmd) inside
						ile_pkg::CMD_READ: begin
							if (in_range) begin
								ram.re    = 1'b1;
								ram.raddr = pos_ext[ile_pkg::ADDR_W-1:0];
								go_rd     = 1'b1;
							end else begin
								rsp_vld        = 1'b1;
								rsp.read_value = '1;
								rsp.status     = ile_pkg::ST_RANGE;
							end
						end
						ile_pkg::CMD_INS_HEAD, ile_pkg::CMD_INS_TAIL,
						ile_pkg::CMD_INS_AT: begin
							if (ins_at > cnt_ext) begin
								rsp_vld    = 1'b1;
								rsp.status = ile_pkg::ST_RANGE;
							end else if (full) begin
								rsp_vld    = 1'b1;
								rsp.status = ile_pkg::ST_FULL;
							end else begin
								go_ins = 1'b1;
							end
						end
						ile_pkg::CMD_DELETE: begin
							if (in_range) begin
								go_del = 1'b1;
							end else begin
								rsp_vld    = 1'b1;
								rsp.status = ile_pkg::ST_RANGE;
							end
						end
						ile_pkg::CMD_CLEAR: begin
							clr           = 1'b1;
							rsp_vld       = 1'b1;
							rsp.count_now = '0;
						end
						default: begin
							rsp_vld = 1'b1;
						end
					endcase
				end
			end
			S_RDWAIT: begin
				rsp_vld        = 1'b1;
				rsp.read_value = rdata;
			end
			S_SHIFT: begin
				ram.we    = pend_s1;
				ram.waddr = waddr_s1;
				ram.wdata = rdata;
				if (left_q != '0) begin
					ram.re    = 1'b1;
					ram.raddr = ptr_q;
				end else if (!pend_s1) begin
					shift_done = 1'b1;
					rsp_vld    = 1'b1;
					if (del_q) begin
						rsp.count_now = ile_pkg::cnt_out_t'(cnt_m1);
					end else begin
						ram.we        = 1'b1;
						ram.waddr     = at_q;
						ram.wdata     = val_q;
						rsp.count_now = ile_pkg::cnt_out_t'(cnt_p1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_SHIFT) && (left_q != '0);
			if (go_rd) begin
				state_q <= S_RDWAIT;
			end else if (go_ins || go_del) begin
				state_q <= S_SHIFT;
			end else if ((state_q == S_RDWAIT) || shift_done) begin
				state_q <= S_IDLE;
			end
			if (clr) begin
				count_q <= '0;
			end else if (shift_done) begin
				count_q <= del_q ? cnt_m1 : cnt_p1;
			end
		end
	end

	// shift loop payload
	always_ff @(posedge clk) begin
		if (go_ins) begin
			at_q   <= ins_at[ile_pkg::ADDR_W-1:0];
			ptr_q  <= cnt_m1[ile_pkg::ADDR_W-1:0];
			left_q <= ins_left[ile_pkg::CNT_W-1:0];
			val_q  <= req.item_value;
			del_q  <= 1'b0;
		end else if (go_del) begin
			at_q   <= pos_ext[ile_pkg::ADDR_W-1:0];
			ptr_q  <= pos_p1[ile_pkg::ADDR_W-1:0];
			left_q <= del_left[ile_pkg::CNT_W-1:0];
			del_q  <= 1'b1;
		end else if ((state_q == S_SHIFT) && (left_q != '0)) begin
			// move the read pointer away from the gap, write one slot behind it
			ptr_q    <= del_q ? ptr_q + ile_pkg::addr_t'(1) : ptr_q - ile_pkg::addr_t'(1);
			waddr_s1 <= del_q ? ptr_q - ile_pkg::addr_t'(1) : ptr_q + ile_pkg::addr_t'(1);
			left_q   <= left_q - ile_pkg::cnt_t'(1);
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ile_pkg::cnt_t'(ile_pkg::CAPACITY))
		else $error("element count above capacity");
	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram.we && ram.re && (ram.waddr == ram.raddr)))
		else $error("read and write of one entry in one cycle");
	a_pend_read: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(ram.re))
		else $error("shift write without a preceding read");
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld |=> (state_q == S_IDLE))
		else $error("sequencer not idle after a result");
`endif

endmodule

/* rtl/core/indexed_list_engine_core.sv */
// Top level of the indexed list engine: sequencer, element RAM, result register.
// Depends on ile_pkg, ile_ram and ile_ctrl.
//
// Usage:
//   Request channel: drive req (cmd, position, item_value) and raise start.
//   The request is taken at a rising edge where start is high and busy low.
//   Result channel: done pulses for one cycle with rsp (read_value, status,
//   count_now). The receiver cannot stall; every result must be taken in its
//   one cycle. Exactly one result per request, in request order.
// Sequencing, from the accepting edge to the edge that takes the result:
//   rejected commands, clear, unused codes: decided in the accepting cycle;
//   busy stays low, so these can follow each other with no gap.
//   read in range: one RAM read (registered data), then the result register.
//   insert: shift L = count - index entries up, then write the new item.
//   delete: shift L = count - index - 1 entries down. The shift loop moves
//   one entry per cycle through the single read and single write port of
//   the element RAM, so an insert at the head of a full-minus-one list
//   moves CAPACITY - 1 entries.
// For reads and shifts, busy is high from the cycle after acceptance until
// the sequencer has produced the result; a new request can be taken while
// done is high.
// Reset clears the element count and the sequencer; RAM contents are left
// as they are, since only entries below the count are ever read.
module indexed_list_engine_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ile_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output ile_pkg::rsp_t rsp
);

	ile_pkg::ram_req_t ram;
	logic [31:0]       rdata;
	logic              rsp_vld;
	ile_pkg::rsp_t     rsp_next;

	// decode, count, shift loop
	ile_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.ram     (ram),
		.rdata   (rdata),
		.rsp_vld (rsp_vld),
		.rsp     (rsp_next)
	);

	// element store: list entry k lives at address k
	ile_ram #(
		.WIDTH (ile_pkg::VAL_W),
		.DEPTH (ile_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	// result register: done marks each result for one cycle; rsp holds the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= rsp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_vld) begin
			rsp <= rsp_next;
		end
	end

endmodule

/* tb/ile_list_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for indexed_list_engine_core: mirrors the stored list, predicts one result
// per accepted request and compares it field by field when done pulses.
// Depends on ile_pkg.
module ile_list_checker
	import ile_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   errors,
	output int   pending
);

	logic signed [VAL_W-1:0] mirror_vals [CAPACITY];
	int                      mirror_count;
	rsp_t                    awaited_rsp [$];

	// Apply one request to the mirror and return the result it must produce.
	function automatic rsp_t apply_list_command(input req_t r);
		rsp_t res;
		int   pos;
		int   at;
		res        = '0;
		res.status = ST_DONE;
		pos        = $signed(r.position);
		case (r.cmd)
			CMD_READ: begin
				if (pos < 0 || pos >= mirror_count) begin
					res.read_value = -1;
					res.status     = ST_RANGE;
				end else begin
					res.read_value = mirror_vals[pos];
				end
			end
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				if (r.cmd == CMD_INS_HEAD)
					at = 0;
				else if (r.cmd == CMD_INS_TAIL)
					at = mirror_count;
				else
					at = (pos < 0) ? 0 : pos;
				// range check comes before the full check
				if (at > mirror_count) begin
					res.status = ST_RANGE;
				end else if (mirror_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int k = mirror_count; k > at; k--)
						mirror_vals[k] = mirror_vals[k - 1];
					mirror_vals[at] = r.item_value;
					mirror_count++;
				end
			end
			CMD_DELETE: begin
				if (pos < 0 || pos >= mirror_count) begin
					res.status = ST_RANGE;
				end else begin
					for (int k = pos; k + 1 < mirror_count; k++)
						mirror_vals[k] = mirror_vals[k + 1];
					mirror_count--;
				end
			end
			CMD_CLEAR: begin
				mirror_count = 0;
			end
			default: ;
		endcase
		res.count_now = cnt_out_t'(mirror_count);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			awaited_rsp.delete();
			mirror_count = 0;
			errors       = 0;
			pending      = 0;
		end else begin
			// retire the result first: a new request may be taken in the same cycle
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					errors++;
					$display("%0t: result with no request waiting: read_value %0d status %0d count_now %0d",
						$time, rsp.read_value, rsp.status, rsp.count_now);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.read_value !== want.read_value) begin
						errors++;
						$display("%0t: read_value expected %0d got %0d",
							$time, want.read_value, rsp.read_value);
					end
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d got %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.count_now !== want.count_now) begin
						errors++;
						$display("%0t: count_now expected %0d got %0d",
							$time, want.count_now, rsp.count_now);
					end
				end
			end
			if (start && !busy)
				awaited_rsp.push_back(apply_list_command(req));
			pending = awaited_rsp.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Top of the indexed list engine testbench: clock, reset, request stimulus and verdict.
// Depends on ile_pkg, indexed_list_engine_core and ile_list_checker.
module tb;
	import ile_pkg::*;

	// Codes the block leaves unused; they must answer done with nothing changed.
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int ITEMS_PER_PHASE = 200;
	// Longest shift moves CAPACITY - 1 entries; random sender gaps also count as quiet.
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 80;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	int errors;
	int pending;
	int idle_pct;
	int delete_pm;
	int quiet_cycles;

	indexed_list_engine_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	ile_list_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: count cycles in which neither a request nor a result moves.
	// A hung sequencer or a lost done ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	// Offer one request and hold it until the block takes it.
	// Idle cycles go in front at the current rate; start stays high across
	// back-to-back requests so no step sees two assignments to it.
	task automatic issue(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic req_t make_request(input logic [2:0] cmd, input int pos,
		input logic [VAL_W-1:0] value);
		req_t r;
		r.cmd        = cmd;
		r.position   = 8'(pos);
		r.item_value = value;
		return r;
	endfunction

	// Random request. Positions mostly land in 0..CAPACITY so inserts at an
	// index and deletes hit the list; the rest are negative or anywhere in
	// the 8-bit field. delete_pm steers the list toward full or toward empty.
	function automatic req_t random_request();
		req_t r;
		int   kind;
		int   pick;
		r.item_value = $urandom;
		kind = $urandom_range(99);
		if (kind < 85)
			r.position = 8'($urandom_range(CAPACITY));
		else if (kind < 95)
			r.position = 8'(-int'($urandom_range(CAPACITY, 1)));
		else
			r.position = 8'($urandom);
		pick = $urandom_range(999);
		if (pick < 4)
			r.cmd = CMD_CLEAR;
		else if (pick < 24)
			r.cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		else if (pick < 224)
			r.cmd = CMD_READ;
		else if (pick < 224 + delete_pm)
			r.cmd = CMD_DELETE;
		else begin
			case ($urandom_range(2))
				0:       r.cmd = CMD_INS_HEAD;
				1:       r.cmd = CMD_INS_TAIL;
				default: r.cmd = CMD_INS_AT;
			endcase
		end
		return r;
	endfunction

	initial begin
		start     = 1'b0;
		req       = '0;
		arst_n    = 1'b0;
		idle_pct  = 0;
		delete_pm = 80;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list rejects first, then build a short list with
		// extreme values, probe every read/delete boundary, and clear.
		issue(make_request(CMD_READ,     0,    32'd0));
		issue(make_request(CMD_DELETE,   0,    32'd0));
		issue(make_request(CMD_INS_AT,   1,    32'h5555_AAAA));  // above count
		issue(make_request(CMD_INS_AT,   -64,  32'h7FFF_FFFF));  // negative index -> head
		issue(make_request(CMD_INS_TAIL, 0,    32'h8000_0000));
		issue(make_request(CMD_INS_HEAD, 0,    32'hFFFF_FFFF));
		issue(make_request(CMD_INS_AT,   3,    32'h1234_5678));  // index == count
		issue(make_request(CMD_INS_AT,   5,    32'h0BAD_F00D));  // above count
		issue(make_request(CMD_INS_AT,   -128, 32'h0000_0000));
		issue(make_request(CMD_READ,     -1,   32'd0));
		issue(make_request(CMD_READ,     5,    32'd0));          // index == count
		issue(make_request(CMD_READ,     127,  32'd0));
		issue(make_request(CMD_READ,     -128, 32'd0));
		issue(make_request(CMD_READ,     4,    32'd0));
		issue(make_request(CMD_READ,     0,    32'd0));
		issue(make_request(CMD_READ,     2,    32'd0));
		issue(make_request(CMD_DELETE,   5,    32'd0));
		issue(make_request(CMD_DELETE,   -1,   32'd0));
		issue(make_request(CMD_DELETE,   4,    32'd0));          // last entry
		issue(make_request(CMD_DELETE,   0,    32'd0));          // head entry
		issue(make_request(CMD_SPARE_LO, $urandom, $urandom));
		issue(make_request(CMD_SPARE_HI, $urandom, $urandom));
		issue(make_request(CMD_CLEAR,    0,    32'd0));
		issue(make_request(CMD_READ,     0,    32'd0));
		issue(make_request(CMD_DELETE,   0,    32'd0));

		// Random phases. Fill phases push the list to CAPACITY and keep it
		// there so full drops show up; drain phases pull it back toward empty.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					// back-to-back requests, list grows
					idle_pct  = 0;
					delete_pm = 80;
				end
				1: begin
					// heavy sender idling, list shrinks
					idle_pct  = 78;
					delete_pm = 450;
				end
				2: begin
					// results cannot be held off, so a receiver stall phase
					// reduces to back-to-back requests; grow the list again
					idle_pct  = 0;
					delete_pm = 80;
				end
				default: begin
					// light idling, mixed traffic
					idle_pct  = 29;
					delete_pm = 250;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				issue(random_request());
		end
		start <= 1'b0;

		// Let every expected result come back, then a quiet tail longer than
		// the slowest shift to catch stray done pulses.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
